>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers shared by the header parser modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property checked every clock, masked while reset is asserted
`define IPH_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);
// antecedent in one cycle implies consequent in the next
`define IPH_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define IPH_ASSERT(lbl, clk, rstn, prop, msg)
`define IPH_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

>>> sv/iph_pkg.sv
// ----------------------------------------------------------------------------
// iph_pkg
// types and constants of the ipv4 / l4 header parser
// ----------------------------------------------------------------------------
package iph_pkg;

  localparam int unsigned CNT_W = 16;
  localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

  // ethernet framing
  localparam logic [3:0] ETH_HDR_LEN  = 4'd14;
  localparam logic [7:0] ETYPE_HI_IDX = 8'd12;
  localparam logic [7:0] ETYPE_LO_IDX = 8'd13;
  localparam logic [7:0] ETYPE_HI     = 8'h08;
  localparam logic [7:0] ETYPE_LO     = 8'h00;

  // ipv4 header
  localparam logic [3:0] IP_VERSION   = 4'd4;
  localparam logic [5:0] IP_MIN_LEN   = 6'd20;
  localparam logic [7:0] IP_TTL_OFS   = 8'd8;
  localparam logic [7:0] IP_PROTO_OFS = 8'd9;
  localparam logic [7:0] IP_SRC_OFS   = 8'd12;

  // transport
  localparam logic [7:0] PROTO_ICMP   = 8'd1;
  localparam logic [7:0] PROTO_TCP    = 8'd6;
  localparam logic [7:0] PROTO_UDP    = 8'd17;
  localparam logic [6:0] TCP_HDR_LEN  = 7'd20;
  localparam logic [6:0] SHORT_L4_LEN = 7'd8;

  // finished packet handed from the ingest side to the parser
  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] len;
    logic             bank;
  } iph_desc_t;

  typedef struct packed {
    logic busy;
    logic bank;
  } iph_parse_stat_t;

  typedef struct packed {
    logic        status;
    logic        eth;
    logic [31:0] src;
    logic [31:0] dst;
    logic [7:0]  proto;
    logic [7:0]  ttl;
    logic [15:0] sport;
    logic [15:0] dport;
    logic        tp;
  } iph_result_t;

  typedef enum logic [3:0] {
    PS_IDLE,
    PS_B12,
    PS_B13,
    PS_VER,
    PS_TTL,
    PS_PROTO,
    PS_ADDR,
    PS_P0,
    PS_P1,
    PS_P2,
    PS_P3,
    PS_DONE
  } iph_state_e;

endpackage

>>> sv/ipv4_l4_header_parser_top.sv
// ----------------------------------------------------------------------------
// ipv4_l4_header_parser_top
// ethernet / ipv4 / tcp-udp-icmp header parser on a byte stream
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while tready is high, and the first
// HEADER_BYTES bytes of each packet go into one of two banks of a
// 2 x 2^clog2(HEADER_BYTES) byte memory while the packet length is counted
// (saturating at 65535). At the last byte the packet is handed to a parse
// sequencer that reads the stored header back through the single memory
// read port, one byte per cycle: the ethertype bytes and the version byte,
// then, for a valid ipv4 header, ttl, protocol and the eight address bytes,
// then the two icmp bytes or the four tcp or udp port bytes, and then it
// loads the output register (waiting while a previous result is held there).
// The next packet fills the other bank meanwhile, so the input runs at one
// byte per cycle as long as packets are at least 19 bytes long; a shorter
// packet holds tready low after its last byte until the parser is free.
// No memory initialization is needed after reset.
`include "assert_macros.svh"

module ipv4_l4_header_parser_top #(
  parameter int unsigned HEADER_BYTES = 128
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,   // data_byte
  input  logic         s_axis_tlast_i,   // last_byte
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // source_address, destination_address, ip_protocol, time_to_live,
  // source_port, destination_port
  output logic [111:0] m_axis_tdata_o,
  // status, ethernet_present, transport_parsed
  output logic [2:0]   m_axis_tuser_o
);
  import iph_pkg::*;

  localparam int unsigned IW = $clog2(HEADER_BYTES);

  iph_desc_t       desc;
  iph_parse_stat_t pstat;
  iph_result_t     res;
  logic            parse_ready;
  logic            wr_en;
  logic [IW:0]     wr_addr;
  logic [7:0]      wr_data;
  logic [IW:0]     rd_addr;
  logic [7:0]      rd_data;
  logic            bank_clash;
  logic            tp_proto_ok;

  iph_ingest #(
    .HEADER_BYTES (HEADER_BYTES),
    .IW           (IW)
  ) u_ingest (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .parse_ready_i   (parse_ready),
    .desc_o          (desc),
    .wr_en_o         (wr_en),
    .wr_addr_o       (wr_addr),
    .wr_data_o       (wr_data)
  );

  iph_hdr_ram #(
    .AW (IW + 1)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  iph_parse #(
    .IW (IW)
  ) u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .desc_i      (desc),
    .ready_o     (parse_ready),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .stat_o      (pstat),
    .res_valid_o (m_axis_tvalid_o),
    .res_ready_i (m_axis_tready_i),
    .res_o       (res)
  );

  assign m_axis_tdata_o = {res.dport, res.sport, res.ttl, res.proto, res.dst, res.src};
  assign m_axis_tuser_o = {res.tp, res.eth, res.status};

  // the intake must never overwrite the bank under parse
  assign bank_clash  = wr_en & pstat.busy & (wr_addr[IW] == pstat.bank);
  assign tp_proto_ok = (res.proto == PROTO_ICMP) | (res.proto == PROTO_TCP)
                     | (res.proto == PROTO_UDP);

  `IPH_ASSERT(a_bank_sep, clk_i, rst_ni, !bank_clash, "bank clash")
  `IPH_ASSERT(a_tp_ok, clk_i, rst_ni, (m_axis_tvalid_o && res.tp) |-> !res.status, "tp with error")
  `IPH_ASSERT(a_tp_proto, clk_i, rst_ni, (m_axis_tvalid_o && res.tp) |-> tp_proto_ok, "tp protocol")

endmodule

>>> sv/iph_hdr_ram.sv
// ----------------------------------------------------------------------------
// iph_hdr_ram
// simple dual-port header byte memory, one write and one registered read
// ----------------------------------------------------------------------------
module iph_hdr_ram #(
  parameter int unsigned AW = 8
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [7:0]    wr_data_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [7:0]    rd_data_o
);

  logic [7:0] mem [2**AW];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> sv/iph_ingest.sv
// ----------------------------------------------------------------------------
// iph_ingest
// byte stream intake: counts bytes, writes the leading ones into the
// current bank and hands finished packets to the parser
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module iph_ingest #(
  parameter int unsigned HEADER_BYTES = 128,
  parameter int unsigned IW           = 7
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [7:0]          s_axis_tdata_i,
  input  logic                s_axis_tlast_i,
  input  logic                parse_ready_i,
  output iph_pkg::iph_desc_t  desc_o,
  output logic                wr_en_o,
  output logic [IW:0]         wr_addr_o,
  output logic [7:0]          wr_data_o
);
  import iph_pkg::*;

  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] count_inc;
  logic             wr_bank_q, wr_bank_d;
  logic             pend_valid_q, pend_valid_d;
  logic [CNT_W-1:0] pend_len_q, pend_len_d;
  logic             pend_bank_q, pend_bank_d;
  logic             take;
  logic             acc;
  logic             acc_last;

  assign take      = pend_valid_q & parse_ready_i;
  // a waiting packet blocks intake until the parser takes it
  assign s_axis_tready_o = ~pend_valid_q | take;
  assign acc       = s_axis_tvalid_i & s_axis_tready_o;
  assign acc_last  = acc & s_axis_tlast_i;
  assign count_inc = (count_q == CNT_MAX) ? count_q : count_q + 1'b1;

  assign wr_en_o   = acc & (count_q < CNT_W'(HEADER_BYTES));
  assign wr_addr_o = {wr_bank_q, count_q[IW-1:0]};
  assign wr_data_o = s_axis_tdata_i;

  always_comb begin
    count_d      = count_q;
    wr_bank_d    = wr_bank_q;
    pend_valid_d = pend_valid_q;
    pend_len_d   = pend_len_q;
    pend_bank_d  = pend_bank_q;
    if (take) begin
      pend_valid_d = 1'b0;
    end
    if (acc) begin
      count_d = count_inc;
    end
    if (acc_last) begin
      count_d      = '0;
      wr_bank_d    = ~wr_bank_q;
      pend_valid_d = 1'b1;
      pend_len_d   = count_inc;
      pend_bank_d  = wr_bank_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      wr_bank_q    <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      count_q      <= count_d;
      wr_bank_q    <= wr_bank_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_len_q  <= pend_len_d;
    pend_bank_q <= pend_bank_d;
  end

  assign desc_o = '{valid: pend_valid_q, len: pend_len_q, bank: pend_bank_q};

  `IPH_ASSERT_NEXT(a_last_pends, clk_i, rst_ni, acc_last, pend_valid_q, "last byte lost")
  `IPH_ASSERT_NEXT(a_bank_flip, clk_i, rst_ni, acc_last, wr_bank_q != $past(wr_bank_q), "bank kept")
  `IPH_ASSERT_NEXT(a_count_clr, clk_i, rst_ni, acc_last, count_q == '0, "count not cleared")

endmodule

>>> sv/iph_parse.sv
// ----------------------------------------------------------------------------
// iph_parse
// header parse sequencer: walks the stored bytes of one packet through the
// memory read port and builds the result in an output register
// ----------------------------------------------------------------------------
module iph_parse #(
  parameter int unsigned IW = 7
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  iph_pkg::iph_desc_t      desc_i,
  output logic                    ready_o,
  output logic [IW:0]             rd_addr_o,
  input  logic [7:0]              rd_data_i,
  output iph_pkg::iph_parse_stat_t stat_o,
  output logic                    res_valid_o,
  input  logic                    res_ready_i,
  output iph_pkg::iph_result_t    res_o
);
  import iph_pkg::*;

  iph_state_e       state_q, state_d;
  logic [CNT_W-1:0] len_q;
  logic             bank_q;
  logic             b12_q;
  logic             eth_q;
  logic [3:0]       off_q;
  logic [5:0]       ihl_q;
  logic             ip_ok_q;
  logic             status_q;
  logic             tp_q;
  logic             icmp_q;
  logic [7:0]       ttl_q;
  logic [7:0]       proto_q;
  logic [63:0]      addr_q;
  logic [2:0]       cnt_q;
  logic [6:0]       l4_q;
  logic [31:0]      l4sh_q;
  logic             out_valid_q, out_valid_d;
  iph_result_t      out_q;

  // decisions taken on the byte that just came back from memory
  logic             eth_now;
  logic [3:0]       off_now;
  logic [CNT_W-1:0] rem;
  logic [5:0]       ihl_now;
  logic             ver_bad;
  logic [6:0]       l4_now;
  logic             has_l4;
  logic             is_tu;
  logic             is_ic;
  logic [6:0]       need;
  logic             l4_short;
  logic             port_go;
  logic             l4_bad;
  logic             out_free;
  logic             out_load;
  logic [7:0]       rd_idx;

  assign eth_now = (len_q >= CNT_W'(ETH_HDR_LEN)) & b12_q & (rd_data_i == ETYPE_LO);
  assign off_now = eth_now ? ETH_HDR_LEN : 4'd0;
  assign rem     = len_q - CNT_W'(off_q);
  assign ihl_now = {rd_data_i[3:0], 2'b00};
  assign ver_bad = (rem < CNT_W'(IP_MIN_LEN)) | (rd_data_i[7:4] != IP_VERSION)
                 | (ihl_now < IP_MIN_LEN) | (CNT_W'(ihl_now) > rem);

  assign l4_now   = 7'(off_q) + 7'(ihl_q);
  assign has_l4   = CNT_W'(l4_now) < len_q;
  assign is_tu    = (proto_q == PROTO_TCP) | (proto_q == PROTO_UDP);
  assign is_ic    = (proto_q == PROTO_ICMP);
  assign need     = (proto_q == PROTO_TCP) ? TCP_HDR_LEN : SHORT_L4_LEN;
  assign l4_short = len_q < (CNT_W'(l4_now) + CNT_W'(need));
  assign port_go  = has_l4 & (is_tu | is_ic) & ~l4_short;
  assign l4_bad   = has_l4 & (is_tu | is_ic) & l4_short;

  assign out_free = ~out_valid_q | res_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      PS_IDLE:  if (desc_i.valid) state_d = PS_B12;
      PS_B12:   state_d = PS_B13;
      PS_B13:   state_d = PS_VER;
      PS_VER:   state_d = ver_bad ? PS_DONE : PS_TTL;
      PS_TTL:   state_d = PS_PROTO;
      PS_PROTO: state_d = PS_ADDR;
      PS_ADDR: begin
        if (cnt_q == 3'd7) begin
          state_d = port_go ? PS_P0 : PS_DONE;
        end
      end
      PS_P0:    state_d = PS_P1;
      PS_P1:    state_d = icmp_q ? PS_DONE : PS_P2;
      PS_P2:    state_d = PS_P3;
      PS_P3:    state_d = PS_DONE;
      PS_DONE:  if (out_free) state_d = PS_IDLE;
      default:  state_d = PS_IDLE;
    endcase
  end

  // read address and result load
  always_comb begin
    rd_idx   = ETYPE_HI_IDX;
    out_load = 1'b0;
    unique case (state_q)
      PS_IDLE:  rd_idx = ETYPE_HI_IDX;
      PS_B12:   rd_idx = ETYPE_LO_IDX;
      PS_B13:   rd_idx = 8'(off_now);
      PS_VER:   rd_idx = 8'(off_q) + IP_TTL_OFS;
      PS_TTL:   rd_idx = 8'(off_q) + IP_PROTO_OFS;
      PS_PROTO: rd_idx = 8'(off_q) + IP_SRC_OFS;
      PS_ADDR: begin
        if (cnt_q == 3'd7) begin
          rd_idx = 8'(l4_now);
        end else begin
          rd_idx = 8'(off_q) + IP_SRC_OFS + 8'(cnt_q) + 8'd1;
        end
      end
      PS_P0:    rd_idx = 8'(l4_q) + 8'd1;
      PS_P1:    rd_idx = 8'(l4_q) + 8'd2;
      PS_P2:    rd_idx = 8'(l4_q) + 8'd3;
      PS_P3:    rd_idx = ETYPE_HI_IDX;
      PS_DONE:  out_load = out_free;
      default:  rd_idx = ETYPE_HI_IDX;
    endcase
  end

  assign ready_o   = (state_q == PS_IDLE);
  assign rd_addr_o = {(state_q == PS_IDLE) ? desc_i.bank : bank_q, rd_idx[IW-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= PS_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // field capture, one byte per step
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      PS_IDLE: begin
        len_q  <= desc_i.len;
        bank_q <= desc_i.bank;
      end
      PS_B12:   b12_q <= (rd_data_i == ETYPE_HI);
      PS_B13: begin
        eth_q <= eth_now;
        off_q <= off_now;
      end
      PS_VER: begin
        ihl_q    <= ihl_now;
        ip_ok_q  <= ~ver_bad;
        status_q <= ver_bad;
        tp_q     <= 1'b0;
      end
      PS_TTL: ttl_q <= rd_data_i;
      PS_PROTO: begin
        proto_q <= rd_data_i;
        cnt_q   <= 3'd0;
      end
      PS_ADDR: begin
        addr_q <= {addr_q[55:0], rd_data_i};
        cnt_q  <= cnt_q + 3'd1;
        if (cnt_q == 3'd7) begin
          l4_q   <= l4_now;
          icmp_q <= is_ic;
          if (l4_bad) begin
            status_q <= 1'b1;
          end
        end
      end
      PS_P0: l4sh_q <= {l4sh_q[23:0], rd_data_i};
      PS_P1: begin
        l4sh_q <= {l4sh_q[23:0], rd_data_i};
        if (icmp_q) begin
          tp_q <= 1'b1;
        end
      end
      PS_P2: l4sh_q <= {l4sh_q[23:0], rd_data_i};
      PS_P3: begin
        l4sh_q <= {l4sh_q[23:0], rd_data_i};
        tp_q   <= 1'b1;
      end
      PS_DONE: begin
        if (out_load) begin
          out_q.status <= status_q;
          out_q.eth    <= eth_q;
          out_q.src    <= ip_ok_q ? addr_q[63:32] : 32'd0;
          out_q.dst    <= ip_ok_q ? addr_q[31:0]  : 32'd0;
          out_q.proto  <= ip_ok_q ? proto_q : 8'd0;
          out_q.ttl    <= ip_ok_q ? ttl_q   : 8'd0;
          out_q.tp     <= tp_q;
          // icmp type and code sit in the low byte of each port field
          if (!tp_q) begin
            out_q.sport <= 16'd0;
            out_q.dport <= 16'd0;
          end else if (icmp_q) begin
            out_q.sport <= {8'd0, l4sh_q[15:8]};
            out_q.dport <= {8'd0, l4sh_q[7:0]};
          end else begin
            out_q.sport <= l4sh_q[31:16];
            out_q.dport <= l4sh_q[15:0];
          end
        end
      end
      default: cnt_q <= 3'd0;
    endcase
  end

  assign stat_o      = '{busy: (state_q != PS_IDLE), bank: bank_q};
  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

>>> sim/ipv4_l4_header_parser_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_l4_header_parser_checker
// watches both stream channels of the header parser and checks every result
// ----------------------------------------------------------------------------
// Keeps its own copy of the leading header bytes and the saturating byte
// count of the packet in flight. At each accepted last byte it parses the
// stored header and queues the expected result; each accepted result
// transaction is compared field by field with the oldest queued one.
module ipv4_l4_header_parser_checker #(
  parameter int unsigned HEADER_BYTES = 128
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  input  logic         s_axis_tready_i,
  input  logic [7:0]   s_axis_tdata_i,   // data_byte
  input  logic         s_axis_tlast_i,   // last_byte
  input  logic         m_axis_tvalid_i,
  input  logic         m_axis_tready_i,
  // source_address, destination_address, ip_protocol, time_to_live,
  // source_port, destination_port
  input  logic [111:0] m_axis_tdata_i,
  // status, ethernet_present, transport_parsed
  input  logic [2:0]   m_axis_tuser_i,
  output int unsigned  fail_count_o,
  output int unsigned  pending_o
);
  import iph_pkg::*;

  logic [7:0]  header_bytes [HEADER_BYTES];
  logic [15:0] packet_len = '0;
  iph_result_t expected_headers [$];
  int unsigned mismatches = 0;

  function automatic logic [7:0] header_byte(input int unsigned idx);
    return (idx < HEADER_BYTES) ? header_bytes[idx] : 8'h00;
  endfunction

  function automatic iph_result_t parse_headers(input int unsigned len);
    iph_result_t r;
    int unsigned ofs;
    int unsigned ihl;
    int unsigned l4;
    int unsigned l4_rem;
    logic [7:0]  ver_ihl;
    r = '0;
    ofs = 0;
    if (len >= ETH_HDR_LEN && header_byte(ETYPE_HI_IDX) == ETYPE_HI &&
        header_byte(ETYPE_LO_IDX) == ETYPE_LO) begin
      ofs = ETH_HDR_LEN;
      r.eth = 1'b1;
    end
    if (len - ofs < IP_MIN_LEN) begin
      r.status = 1'b1;
      return r;
    end
    ver_ihl = header_byte(ofs);
    ihl = ver_ihl[3:0] * 4;
    if (ver_ihl[7:4] != IP_VERSION || ihl < IP_MIN_LEN || ihl > len - ofs) begin
      r.status = 1'b1;
      return r;
    end
    r.ttl   = header_byte(ofs + IP_TTL_OFS);
    r.proto = header_byte(ofs + IP_PROTO_OFS);
    r.src   = {header_byte(ofs + IP_SRC_OFS),     header_byte(ofs + IP_SRC_OFS + 1),
               header_byte(ofs + IP_SRC_OFS + 2), header_byte(ofs + IP_SRC_OFS + 3)};
    r.dst   = {header_byte(ofs + IP_SRC_OFS + 4), header_byte(ofs + IP_SRC_OFS + 5),
               header_byte(ofs + IP_SRC_OFS + 6), header_byte(ofs + IP_SRC_OFS + 7)};
    l4 = ofs + ihl;
    // ip header runs up to the packet end: nothing left for a port header
    if (l4 >= len) return r;
    l4_rem = len - l4;
    if (r.proto == PROTO_TCP || r.proto == PROTO_UDP) begin
      if (l4_rem < ((r.proto == PROTO_TCP) ? TCP_HDR_LEN : SHORT_L4_LEN)) begin
        r.status = 1'b1;
      end else begin
        r.sport = {header_byte(l4), header_byte(l4 + 1)};
        r.dport = {header_byte(l4 + 2), header_byte(l4 + 3)};
        r.tp    = 1'b1;
      end
    end else if (r.proto == PROTO_ICMP) begin
      if (l4_rem < SHORT_L4_LEN) begin
        r.status = 1'b1;
      end else begin
        // icmp type and code go out on the port fields
        r.sport = {8'h00, header_byte(l4)};
        r.dport = {8'h00, header_byte(l4 + 1)};
        r.tp    = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    iph_result_t want;
    iph_result_t got;
    if (!rst_ni) begin
      packet_len = '0;
      expected_headers.delete();
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.src    = m_axis_tdata_i[31:0];
        got.dst    = m_axis_tdata_i[63:32];
        got.proto  = m_axis_tdata_i[71:64];
        got.ttl    = m_axis_tdata_i[79:72];
        got.sport  = m_axis_tdata_i[95:80];
        got.dport  = m_axis_tdata_i[111:96];
        got.status = m_axis_tuser_i[0];
        got.eth    = m_axis_tuser_i[1];
        got.tp     = m_axis_tuser_i[2];
        if (expected_headers.size() == 0) begin
          $error("result transaction with no packet outstanding");
          mismatches++;
        end else begin
          want = expected_headers.pop_front();
          check_field("status", want.status, got.status);
          check_field("ethernet_present", want.eth, got.eth);
          check_field("source_address", want.src, got.src);
          check_field("destination_address", want.dst, got.dst);
          check_field("ip_protocol", want.proto, got.proto);
          check_field("time_to_live", want.ttl, got.ttl);
          check_field("source_port", want.sport, got.sport);
          check_field("destination_port", want.dport, got.dport);
          check_field("transport_parsed", want.tp, got.tp);
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        if (packet_len < HEADER_BYTES) header_bytes[packet_len] = s_axis_tdata_i;
        if (packet_len != CNT_MAX) packet_len++;
        if (s_axis_tlast_i) begin
          expected_headers.push_back(parse_headers(packet_len));
          packet_len = '0;
        end
      end
    end
    pending_o    <= expected_headers.size();
    fail_count_o <= mismatches;
  end

endmodule

>>> sim/ipv4_l4_header_parser_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_l4_header_parser_top_test
// stimulus and verdict for the ipv4 / l4 header parser
// ----------------------------------------------------------------------------
// Sends a directed set of packets (every header case, packets longer than
// the stored header), then random packets, mostly well formed with random
// content, some cut short or corrupted, some plain noise, over phases of
// sender and receiver idling. The checker beside the block predicts and
// compares.
module ipv4_l4_header_parser_top_test;
  import iph_pkg::*;

  localparam int unsigned HEADER_BYTES = 128;
  localparam int unsigned CYCLE_LIMIT  = 1000000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [7:0]   s_axis_tdata_i = '0;
  logic         s_axis_tlast_i = 1'b0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [111:0] m_axis_tdata_o;
  logic [2:0]   m_axis_tuser_o;

  int unsigned  failures;
  int unsigned  results_pending;
  int unsigned  cycle_count = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;
  logic [7:0]   packet_bytes [$];

  always #5 clk_i = ~clk_i;

  ipv4_l4_header_parser_top #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  ipv4_l4_header_parser_checker #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_i  (m_axis_tdata_o),
    .m_axis_tuser_i  (m_axis_tuser_o),
    .fail_count_o    (failures),
    .pending_o       (results_pending)
  );

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic fill_packet(input int unsigned len, input bit random_fill,
                             input logic [7:0] value);
    packet_bytes.delete();
    repeat (len) packet_bytes.push_back(random_fill ? 8'($urandom) : value);
  endtask

  // optional ethernet header, ipv4 header with random fields, then l4_len
  // random bytes behind it
  task automatic build_ipv4(input bit eth, input logic [3:0] ver,
                            input logic [3:0] ihl_words, input logic [7:0] proto,
                            input int unsigned l4_len);
    int unsigned ip_len;
    packet_bytes.delete();
    if (eth) begin
      repeat (12) packet_bytes.push_back(8'($urandom));
      packet_bytes.push_back(ETYPE_HI);
      packet_bytes.push_back(ETYPE_LO);
    end
    ip_len = (ihl_words < 5) ? IP_MIN_LEN : ihl_words * 4;
    packet_bytes.push_back({ver, ihl_words});
    for (int i = 1; i < ip_len; i++) begin
      packet_bytes.push_back((i == IP_PROTO_OFS) ? proto : 8'($urandom));
    end
    repeat (l4_len) packet_bytes.push_back(8'($urandom));
  endtask

  task automatic random_packet();
    int unsigned pick;
    int unsigned l4_len;
    int unsigned cut;
    bit          eth;
    logic [7:0]  proto;
    logic [3:0]  ihl_words;
    pick = $urandom_range(99);
    if (pick >= 85) begin
      fill_packet($urandom_range(1, 48), 1'b1, 8'h00);
      return;
    end
    case ($urandom_range(4))
      0:       proto = PROTO_TCP;
      1:       proto = PROTO_UDP;
      2:       proto = PROTO_ICMP;
      3:       proto = PROTO_TCP;
      default: proto = 8'($urandom);
    endcase
    eth = 1'($urandom_range(1));
    ihl_words = ($urandom_range(3) == 0) ? 4'($urandom_range(5, 15)) : 4'd5;
    if ($urandom_range(24) == 0) begin
      l4_len = $urandom_range(100, 300);
    end else if ($urandom_range(1) == 0) begin
      // around the transport minimums
      l4_len = $urandom_range(0, 24);
    end else begin
      l4_len = $urandom_range(0, 40);
    end
    build_ipv4(eth, IP_VERSION, ihl_words, proto, l4_len);
    if (pick >= 70) begin
      if ($urandom_range(1) == 0) begin
        cut = $urandom_range(1, packet_bytes.size());
        packet_bytes = packet_bytes[0:cut-1];
      end else begin
        packet_bytes[eth ? ETH_HDR_LEN : 0] = 8'($urandom);
      end
    end
  endtask

  task automatic push_byte(input logic [7:0] data, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= data;
    s_axis_tlast_i  <= last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  task automatic send_packet();
    foreach (packet_bytes[i]) push_byte(packet_bytes[i], i == packet_bytes.size() - 1);
  endtask

  task automatic wait_results_drained();
    do @(posedge clk_i); while (results_pending != 0);
  endtask

  initial begin
    int unsigned phase_bytes;
    int unsigned phase_packets;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    fill_packet(1, 1'b0, 8'h00);  send_packet();
    fill_packet(1, 1'b0, 8'hFF);  send_packet();
    fill_packet(30, 1'b0, 8'h00); send_packet();
    fill_packet(30, 1'b0, 8'hFF); send_packet();
    build_ipv4(1'b0, IP_VERSION, 4'd5, PROTO_TCP, 20);  send_packet();
    build_ipv4(1'b1, IP_VERSION, 4'd5, PROTO_UDP, 8);   send_packet();
    build_ipv4(1'b1, IP_VERSION, 4'd6, PROTO_ICMP, 8);  send_packet();
    // transport header one byte short
    build_ipv4(1'b0, IP_VERSION, 4'd5, PROTO_TCP, 19);  send_packet();
    build_ipv4(1'b1, IP_VERSION, 4'd5, PROTO_UDP, 7);   send_packet();
    build_ipv4(1'b0, IP_VERSION, 4'd5, PROTO_ICMP, 7);  send_packet();
    build_ipv4(1'b0, IP_VERSION, 4'd5, 8'd47, 12);      send_packet();
    build_ipv4(1'b1, IP_VERSION, 4'd5, 8'hFF, 0);       send_packet();
    build_ipv4(1'b0, IP_VERSION, 4'd5, PROTO_TCP, 0);   send_packet();
    build_ipv4(1'b1, IP_VERSION, 4'd15, PROTO_TCP, 20); send_packet();
    build_ipv4(1'b0, 4'd6, 4'd5, PROTO_UDP, 8);         send_packet();
    build_ipv4(1'b1, IP_VERSION, 4'd4, PROTO_UDP, 8);   send_packet();
    // header length beyond the packet end
    build_ipv4(1'b0, IP_VERSION, 4'd8, PROTO_UDP, 8);
    packet_bytes = packet_bytes[0:24];
    send_packet();
    build_ipv4(1'b0, IP_VERSION, 4'd5, PROTO_UDP, 0);
    packet_bytes = packet_bytes[0:18];
    send_packet();
    // ethernet header and nothing behind it
    build_ipv4(1'b1, IP_VERSION, 4'd5, PROTO_UDP, 0);
    packet_bytes = packet_bytes[0:ETH_HDR_LEN-1];
    send_packet();
    // raw ip whose source address looks like an ethertype
    build_ipv4(1'b0, IP_VERSION, 4'd5, PROTO_UDP, 40);
    packet_bytes[ETYPE_HI_IDX] = ETYPE_HI;
    packet_bytes[ETYPE_LO_IDX] = ETYPE_LO;
    packet_bytes[ETH_HDR_LEN]  = {IP_VERSION, 4'd5};
    send_packet();
    build_ipv4(1'b1, IP_VERSION, 4'd5, PROTO_UDP, 8);
    packet_bytes[ETYPE_LO_IDX] = 8'h01;
    send_packet();
    // longer than the stored header
    build_ipv4(1'b1, IP_VERSION, 4'd5, PROTO_TCP, 120); send_packet();

    // sender holds off until every result is back
    s_axis_tvalid_i <= 1'b0;
    wait_results_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      phase_bytes = 0;
      phase_packets = 0;
      while (phase_bytes < 170 || phase_packets < 3) begin
        random_packet();
        send_packet();
        phase_bytes += packet_bytes.size();
        phase_packets++;
      end
    end

    s_axis_tvalid_i <= 1'b0;
    wait_results_drained();
    repeat (40) @(posedge clk_i);
    if (failures == 0 && results_pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
